@@ rtl/core/scpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

  localparam int FUNC_W     = 2;
  localparam int REQ_W      = 13;
  localparam int OFF_W      = 12;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FREE     = 2'd1,
    FUNC_FREE_ALL = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_PAGE   = 2'd1,
    ST_FEW_PAGES = 2'd2,
    ST_NO_RUN    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_SPLIT = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_TAIL  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_GRANT_RD,
    S_GRANT_WB,
    S_SCAN,
    S_MARK,
    S_FREE_RUN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/scpa_link_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpa_link_ram #(
  parameter int AW = 8,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/size_class_page_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Size-class page allocator.
// Input channel s_axis: one beat is one command. tuser carries the function
// (allocate, free one allocation, free everything), tdata the request size and
// the offset to free. Output channel m_axis: one beat per command with the
// granted byte offset and a status code (ok, no free page, too few free pages,
// no consecutive run). cfg_we/cfg_wdata set the number of managed pages and
// re-initialize the whole arena in the same cycle; write only while idle.
// Steps of each command after its accept, before the response:
//   free-all, unknown function, ignored or block free, too few pages: execute
//   small allocate from a listed page: execute, read grant, write back head
//   small allocate that splits a fresh page: link each block, then as above
//   large allocate: scan pages, then mark the run (no run: every managed page)
//   free of a run: release the run pages (one page released a cycle)
// One command is in flight at a time; the page-table walks and the block
// link memory, whose read port is registered, set the pace of each command.
// A result waits in the output register while the receiver stalls; the next
// command is taken meanwhile and holds in its last step until the register
// frees. Reset empties every page, fills the free-page stack in ascending
// order and manages all NUM_PAGES pages; no clearing pass is needed.
module size_class_page_allocator #(
  parameter int NUM_PAGES  = 16,
  parameter int PAGE_BYTES = 256,
  parameter int MIN_BLOCK  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [scpa_pkg::CFG_W-1:0]         cfg_wdata,      // pages_in_use
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [12:0] request_bytes, [24:13] free_offset, [31:25] zero
  input  logic [scpa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [scpa_pkg::FUNC_W-1:0]        s_axis_tuser,   // [1:0] func
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [11:0] grant_offset, [13:12] status, [15:14] zero
  output logic [scpa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import scpa_pkg::*;

  localparam int PG_W    = $clog2(NUM_PAGES);
  localparam int TOP_W   = $clog2(NUM_PAGES + 1);
  localparam int BLOCKS  = PAGE_BYTES / MIN_BLOCK;
  localparam int BLK_W   = $clog2(BLOCKS);
  localparam int NCLASS  = BLK_W;
  localparam int CL_W    = (NCLASS > 1) ? $clog2(NCLASS) : 1;
  localparam int PG_SH   = $clog2(PAGE_BYTES);
  localparam int MB_SH   = $clog2(MIN_BLOCK);
  localparam int CNT_MAX = (BLOCKS > NUM_PAGES) ? BLOCKS : NUM_PAGES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int LA_W    = PG_W + BLK_W;

  // Control and command registers
  state_t              state, state_next;
  logic [TOP_W-1:0]    pim;
  func_t               func_q;
  logic [REQ_W-1:0]    bytes_q;
  logic [OFF_W-1:0]    off_q;

  // Page table
  kind_t               kind   [NUM_PAGES];
  logic [CL_W-1:0]     pclass [NUM_PAGES];
  logic [CNT_W-1:0]    pcount [NUM_PAGES];
  logic [BLK_W-1:0]    phead  [NUM_PAGES];
  // Free-page stack kept as a position per page
  logic [NUM_PAGES-1:0] in_stack;
  logic [PG_W-1:0]     spos   [NUM_PAGES];
  logic [TOP_W-1:0]    top;
  // Class lists kept as a rank per page
  logic [NUM_PAGES-1:0] listed;
  logic [PG_W-1:0]     rank   [NUM_PAGES];
  logic [TOP_W-1:0]    clen   [NCLASS];

  // Walk registers
  logic [PG_W-1:0]     cur_page, cur_page_next;
  logic [CL_W-1:0]     cur_class, cur_class_next;
  logic [BLK_W-1:0]    link_i, link_i_next;
  logic [TOP_W-1:0]    scan_i, scan_i_next;
  logic [TOP_W-1:0]    got, got_next;
  logic [PG_W-1:0]     start, start_next;
  logic [TOP_W-1:0]    amount, amount_next;
  logic [TOP_W:0]      run_end, run_end_next;
  logic [OFF_W-1:0]    grant_q, grant_next;
  status_t             status_q, status_next;

  // Page-table update requests
  logic                pf_kind_we, pf_count_we, pf_head_we, pf_class_we;
  logic [PG_W-1:0]     pf_page;
  kind_t               pf_kind;
  logic [CNT_W-1:0]    pf_count;
  logic [BLK_W-1:0]    pf_head;
  logic [CL_W-1:0]     pf_class;
  logic                srm_en, spush_en, lrm_en, lpush_en, clr_all, out_load;
  logic [PG_W-1:0]     srm_page, spush_page, lrm_page, lpush_page;
  logic [CL_W-1:0]     lrm_cls, lpush_cls;

  // Link memory
  logic                ram_we;
  logic [LA_W-1:0]     ram_waddr, ram_raddr;
  logic [BLK_W-1:0]    ram_wdata, ram_rdata;

  // Decoded values
  logic [CL_W-1:0]     req_cls;
  logic                req_small;
  logic [CNT_W-1:0]    req_bpp, cur_bpp, f_bpp, f_inc;
  logic [31:0]         amt32, off_pg32, off_in32, grant32;
  logic [PG_W-1:0]     fp, top_pg, head_pg, scan_pg;
  logic [CL_W-1:0]     f_cls;
  logic [BLK_W-1:0]    f_idx;
  logic                f_valid;
  logic [TOP_W-1:0]    top_m1, pim_cfg;
  logic [TOP_W:0]      link_nx, mark_end;

  scpa_link_ram #(.AW(LA_W), .DW(BLK_W)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);

  // Saturate the configured page count into 1..NUM_PAGES
  always_comb begin
    if (cfg_wdata == '0) begin
      pim_cfg = TOP_W'(1);
    end else if (32'(cfg_wdata) > NUM_PAGES) begin
      pim_cfg = TOP_W'(NUM_PAGES);
    end else begin
      pim_cfg = TOP_W'(cfg_wdata);
    end
  end

  // Smallest class that holds the request
  always_comb begin
    req_cls = CL_W'(NCLASS - 1);
    for (int c = NCLASS - 1; c >= 0; c--) begin
      if ((32'(MIN_BLOCK) << c) >= 32'(bytes_q)) begin
        req_cls = CL_W'(c);
      end
    end
  end

  assign req_small = 32'(bytes_q) <= 32'(PAGE_BYTES / 2);
  assign req_bpp   = CNT_W'(BLOCKS) >> req_cls;
  assign cur_bpp   = CNT_W'(BLOCKS) >> cur_class;
  assign amt32     = (32'(bytes_q) + 32'(PAGE_BYTES - 1)) >> PG_SH;
  assign top_m1    = top - TOP_W'(1);

  // Top of the free stack and head page of the requested class
  always_comb begin
    top_pg  = '0;
    head_pg = '0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (in_stack[p] && (TOP_W'(spos[p]) == top_m1)) begin
        top_pg = PG_W'(p);
      end
      if (listed[p] && (pclass[p] == req_cls) && (rank[p] == '0)) begin
        head_pg = PG_W'(p);
      end
    end
  end

  // Decode of a free
  assign off_pg32 = 32'(off_q) >> PG_SH;
  assign off_in32 = 32'(off_q) & 32'(PAGE_BYTES - 1);
  assign f_valid  = off_pg32 < 32'(pim);
  assign fp       = off_pg32[PG_W-1:0];
  assign f_cls    = pclass[fp];
  assign f_idx    = BLK_W'(off_in32 >> (MB_SH + 32'(f_cls)));
  assign f_bpp    = CNT_W'(BLOCKS) >> f_cls;
  assign f_inc    = pcount[fp] + CNT_W'(1);

  assign scan_pg  = scan_i[PG_W-1:0];
  assign link_nx  = (TOP_W + 1)'(link_i) + (TOP_W + 1)'(1);
  assign mark_end = (TOP_W + 1)'(start) + (TOP_W + 1)'(amount);
  assign grant32  = (32'(cur_page) << PG_SH)
                  + (32'(phead[cur_page]) << (MB_SH + 32'(cur_class)));

  // Sequencer
  always_comb begin
    state_next     = state;
    cur_page_next  = cur_page;
    cur_class_next = cur_class;
    link_i_next    = link_i;
    scan_i_next    = scan_i;
    got_next       = got;
    start_next     = start;
    amount_next    = amount;
    run_end_next   = run_end;
    grant_next     = grant_q;
    status_next    = status_q;
    pf_kind_we     = 1'b0;
    pf_count_we    = 1'b0;
    pf_head_we     = 1'b0;
    pf_class_we    = 1'b0;
    pf_page        = cur_page;
    pf_kind        = KIND_FREE;
    pf_count       = '0;
    pf_head        = '0;
    pf_class       = cur_class;
    srm_en         = 1'b0;
    srm_page       = cur_page;
    spush_en       = 1'b0;
    spush_page     = cur_page;
    lrm_en         = 1'b0;
    lrm_page       = cur_page;
    lrm_cls        = cur_class;
    lpush_en       = 1'b0;
    lpush_page     = cur_page;
    lpush_cls      = cur_class;
    clr_all        = 1'b0;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = {cur_page, link_i};
    ram_wdata      = '0;
    ram_raddr      = {cur_page, phead[cur_page]};

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          grant_next  = '0;
          status_next = ST_OK;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_RESP;
        case (func_q)
          FUNC_ALLOC: begin
            if (req_small) begin
              if (clen[req_cls] != '0) begin
                cur_page_next  = head_pg;
                cur_class_next = req_cls;
                state_next     = S_GRANT_RD;
              end else if (top == '0) begin
                status_next = ST_NO_PAGE;
              end else begin
                // Pop a fresh page and split it
                srm_en         = 1'b1;
                srm_page       = top_pg;
                pf_page        = top_pg;
                pf_kind_we     = 1'b1;
                pf_kind        = KIND_SPLIT;
                pf_class_we    = 1'b1;
                pf_class       = req_cls;
                pf_count_we    = 1'b1;
                pf_count       = req_bpp;
                pf_head_we     = 1'b1;
                pf_head        = '0;
                lpush_en       = 1'b1;
                lpush_page     = top_pg;
                lpush_cls      = req_cls;
                cur_page_next  = top_pg;
                cur_class_next = req_cls;
                link_i_next    = '0;
                state_next     = S_LINK;
              end
            end else if (amt32 > 32'(top)) begin
              status_next = ST_FEW_PAGES;
            end else begin
              amount_next = TOP_W'(amt32);
              scan_i_next = '0;
              got_next    = '0;
              start_next  = '0;
              state_next  = S_SCAN;
            end
          end

          FUNC_FREE: begin
            if (f_valid) begin
              case (kind[fp])
                KIND_SPLIT: begin
                  ram_we     = 1'b1;
                  ram_waddr  = {fp, f_idx};
                  ram_wdata  = phead[fp];
                  pf_page    = fp;
                  pf_head_we = 1'b1;
                  pf_head    = f_idx;
                  pf_count_we = 1'b1;
                  if (f_inc >= f_bpp) begin
                    // Page fully back: return it to the stack
                    pf_kind_we = 1'b1;
                    pf_kind    = KIND_FREE;
                    pf_count   = '0;
                    spush_en   = 1'b1;
                    spush_page = fp;
                    lrm_en     = 1'b1;
                    lrm_page   = fp;
                    lrm_cls    = f_cls;
                  end else begin
                    pf_count = f_inc;
                    if (pcount[fp] == '0) begin
                      lpush_en   = 1'b1;
                      lpush_page = fp;
                      lpush_cls  = f_cls;
                    end
                  end
                end
                KIND_RUN: begin
                  cur_page_next = fp;
                  scan_i_next   = TOP_W'(fp);
                  run_end_next  = (TOP_W + 1)'(fp) + (TOP_W + 1)'(pcount[fp]);
                  state_next    = S_FREE_RUN;
                end
                default: begin
                end
              endcase
            end
          end

          FUNC_FREE_ALL: begin
            clr_all = 1'b1;
          end

          default: begin
          end
        endcase
      end

      S_LINK: begin
        // Chain the blocks of a fresh page, last one links to block zero
        ram_we    = 1'b1;
        ram_waddr = {cur_page, link_i};
        ram_wdata = ((TOP_W + 1)'(cur_bpp) > link_nx) ? BLK_W'(link_nx) : '0;
        link_i_next = BLK_W'(link_nx);
        if ((TOP_W + 1)'(cur_bpp) == link_nx) begin
          state_next = S_GRANT_RD;
        end
      end

      S_GRANT_RD: begin
        grant_next = grant32[OFF_W-1:0];
        state_next = S_GRANT_WB;
      end

      S_GRANT_WB: begin
        pf_head_we  = 1'b1;
        pf_head     = ram_rdata;
        pf_count_we = 1'b1;
        pf_count    = pcount[cur_page] - CNT_W'(1);
        if (pcount[cur_page] == CNT_W'(1)) begin
          lrm_en = 1'b1;
        end
        state_next = S_RESP;
      end

      S_SCAN: begin
        if (scan_i == pim) begin
          status_next = ST_NO_RUN;
          state_next  = S_RESP;
        end else if (kind[scan_pg] == KIND_FREE) begin
          if (got == '0) begin
            start_next = scan_pg;
          end
          got_next = got + TOP_W'(1);
          if ((got + TOP_W'(1)) == amount) begin
            scan_i_next = (got == '0) ? scan_i : TOP_W'(start);
            state_next  = S_MARK;
          end else begin
            scan_i_next = scan_i + TOP_W'(1);
          end
        end else begin
          got_next    = '0;
          scan_i_next = scan_i + TOP_W'(1);
        end
      end

      S_MARK: begin
        pf_page     = scan_pg;
        pf_kind_we  = 1'b1;
        pf_kind     = (scan_pg == start) ? KIND_RUN : KIND_TAIL;
        pf_count_we = 1'b1;
        pf_count    = CNT_W'(amount);
        srm_en      = in_stack[scan_pg];
        srm_page    = scan_pg;
        scan_i_next = scan_i + TOP_W'(1);
        if ((TOP_W + 1)'(scan_i) + (TOP_W + 1)'(1) == mark_end) begin
          grant_next = OFF_W'(32'(start) << PG_SH);
          state_next = S_RESP;
        end
      end

      S_FREE_RUN: begin
        if (((TOP_W + 1)'(scan_i) < run_end) && (scan_i < pim) &&
            ((scan_pg == cur_page) || (kind[scan_pg] == KIND_TAIL))) begin
          pf_page     = scan_pg;
          pf_kind_we  = 1'b1;
          pf_kind     = KIND_FREE;
          pf_count_we = 1'b1;
          pf_count    = '0;
          spush_en    = 1'b1;
          spush_page  = scan_pg;
          scan_i_next = scan_i + TOP_W'(1);
        end else begin
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        // Hold until the output register frees
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q  <= func_t'(s_axis_tuser);
      bytes_q <= s_axis_tdata[REQ_W-1:0];
      off_q   <= s_axis_tdata[REQ_W +: OFF_W];
    end
    cur_page  <= cur_page_next;
    cur_class <= cur_class_next;
    link_i    <= link_i_next;
    scan_i    <= scan_i_next;
    got       <= got_next;
    start     <= start_next;
    amount    <= amount_next;
    run_end   <= run_end_next;
    grant_q   <= grant_next;
    status_q  <= status_next;
    if (out_load) begin
      m_axis_tdata <= OUT_DATA_W'({status_q, grant_q});
    end
  end

  // Page table, free stack and class lists
  always_ff @(posedge clk) begin
    if (rst || cfg_we || clr_all) begin
      // Re-initialize the arena
      for (int p = 0; p < NUM_PAGES; p++) begin
        kind[p]   <= KIND_FREE;
        pclass[p] <= '0;
        pcount[p] <= '0;
        phead[p]  <= '0;
        spos[p]   <= PG_W'(p);
        rank[p]   <= '0;
        if (rst) begin
          in_stack[p] <= 1'b1;
        end else if (cfg_we) begin
          in_stack[p] <= 32'(p) < 32'(pim_cfg);
        end else begin
          in_stack[p] <= 32'(p) < 32'(pim);
        end
      end
      listed <= '0;
      for (int c = 0; c < NCLASS; c++) begin
        clen[c] <= '0;
      end
      if (rst) begin
        pim <= TOP_W'(NUM_PAGES);
        top <= TOP_W'(NUM_PAGES);
      end else if (cfg_we) begin
        pim <= pim_cfg;
        top <= pim_cfg;
      end else begin
        top <= pim;
      end
    end else begin
      if (pf_kind_we) begin
        kind[pf_page] <= pf_kind;
      end
      if (pf_count_we) begin
        pcount[pf_page] <= pf_count;
      end
      if (pf_head_we) begin
        phead[pf_page] <= pf_head;
      end
      if (pf_class_we) begin
        pclass[pf_page] <= pf_class;
      end

      // Drop a page from the stack, close the gap
      if (srm_en) begin
        for (int q = 0; q < NUM_PAGES; q++) begin
          if (in_stack[q] && (spos[q] > spos[srm_page])) begin
            spos[q] <= spos[q] - PG_W'(1);
          end
        end
        in_stack[srm_page] <= 1'b0;
        top <= top - TOP_W'(1);
      end else if (spush_en && (top < TOP_W'(NUM_PAGES))) begin
        in_stack[spush_page] <= 1'b1;
        spos[spush_page]     <= PG_W'(top);
        top <= top + TOP_W'(1);
      end

      // Drop a page from its class list, close the gap
      if (lrm_en && listed[lrm_page]) begin
        for (int q = 0; q < NUM_PAGES; q++) begin
          if (listed[q] && (pclass[q] == lrm_cls) && (rank[q] > rank[lrm_page])) begin
            rank[q] <= rank[q] - PG_W'(1);
          end
        end
        listed[lrm_page] <= 1'b0;
        clen[lrm_cls]    <= clen[lrm_cls] - TOP_W'(1);
      end else if (lpush_en && (clen[lpush_cls] < TOP_W'(NUM_PAGES))) begin
        listed[lpush_page] <= 1'b1;
        rank[lpush_page]   <= PG_W'(clen[lpush_cls]);
        clen[lpush_cls]    <= clen[lpush_cls] + TOP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/scpa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [scpa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import scpa_pkg::*;

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // A failed allocation never carries an offset
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[13:12] != ST_OK) |-> (m_axis_tdata[11:0] == '0))
    else $error("nonzero offset with failure status");

  // One command at a time: no accept in the cycle after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  // A command's result never shows directly after its accept
  a_min_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (m_axis_tready || !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result ahead of its command");

endmodule

bind size_class_page_allocator scpa_checker u_scpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/size_class_page_allocator_tb.sv @@
`timescale 1ns / 1ps

module size_class_page_allocator_tb;
  import scpa_pkg::*;

  localparam int PAGES     = 16;
  localparam int PAGE_SZ   = 256;
  localparam int MIN_BLK   = 16;
  localparam int BLK_MAX   = PAGE_SZ / MIN_BLK;
  localparam int NCLASS    = 4;     // 16, 32, 64, 128 bytes
  localparam int SETTLE    = 48;    // covers the slowest command (run of 16)
  localparam int WATCHDOG  = 20000;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 320;
  localparam int HOLD_LEN  = 200;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    func_t       func;
    int          bytes;
    int          offset;
    bit          typed;
    logic [11:0] grant;
    status_t     status;
  } row_t;

  typedef struct {
    logic [11:0] grant;
    status_t     status;
  } grant_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  size_class_page_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Arena mirror: page table, block chains, free-page stack and class lists.
  // ---------------------------------------------------------------------------
  int    managed;
  kind_t pg_kind  [PAGES];
  int    pg_class [PAGES];
  int    pg_count [PAGES];
  int    pg_head  [PAGES];
  int    blk_next [PAGES*BLK_MAX];
  int    stk      [PAGES];
  int    stk_top;
  int    cls_pages[NCLASS][PAGES];
  int    cls_len  [NCLASS];

  function void arena_reset();
    for (int p = 0; p < PAGES; p++) begin
      pg_kind[p]  = KIND_FREE;
      pg_class[p] = 0;
      pg_count[p] = 0;
      pg_head[p]  = 0;
      stk[p]      = (p < managed) ? p : 0;
    end
    foreach (blk_next[i]) blk_next[i] = 0;
    for (int c = 0; c < NCLASS; c++) begin
      cls_len[c] = 0;
      for (int p = 0; p < PAGES; p++) cls_pages[c][p] = 0;
    end
    stk_top = managed;
  endfunction

  // Drop a page from a class list, keeping the others in order.
  function void class_drop(int c, int page);
    int k;
    k = 0;
    for (int i = 0; i < cls_len[c]; i++)
      if (cls_pages[c][i] != page) begin
        cls_pages[c][k] = cls_pages[c][i];
        k++;
      end
    cls_len[c] = k;
  endfunction

  function void class_add(int c, int page);
    if (cls_len[c] < PAGES) begin
      cls_pages[c][cls_len[c]] = page;
      cls_len[c]++;
    end
  endfunction

  function void stack_add(int page);
    if (stk_top < PAGES) begin
      stk[stk_top] = page;
      stk_top++;
    end
  endfunction

  function void stack_drop(int page);
    int k;
    k = 0;
    for (int i = 0; i < stk_top; i++)
      if (stk[i] != page) begin
        stk[k] = stk[i];
        k++;
      end
    stk_top = k;
  endfunction

  // Small request: first listed page of the class, else split a fresh page.
  function status_t carve_block(int bytes, output int grant);
    int c, cs, bpp, page, head;
    c = 0;
    while ((MIN_BLK << c) < bytes) c++;
    cs = MIN_BLK << c;
    if (cls_len[c] == 0) begin
      bpp = PAGE_SZ / cs;
      if (stk_top == 0) return ST_NO_PAGE;
      stk_top--;
      page = stk[stk_top];
      pg_kind[page]  = KIND_SPLIT;
      pg_class[page] = c;
      pg_count[page] = bpp;
      pg_head[page]  = 0;
      for (int i = 0; i < bpp; i++)
        blk_next[page*BLK_MAX + i] = (i + 1 < bpp) ? i + 1 : 0;
      class_add(c, page);
    end
    page  = cls_pages[c][0];
    head  = pg_head[page];
    grant = page * PAGE_SZ + head * cs;
    pg_head[page] = blk_next[page*BLK_MAX + head];
    if (pg_count[page] > 0) pg_count[page]--;
    if (pg_count[page] == 0) class_drop(c, page);
    return ST_OK;
  endfunction

  // Large request: lowest first-fit run of consecutive free pages.
  function status_t claim_run(int bytes, output int grant);
    int want, start, got;
    want  = (bytes + PAGE_SZ - 1) / PAGE_SZ;
    start = 0;
    got   = 0;
    if (want > stk_top) return ST_FEW_PAGES;
    for (int i = 0; i < managed; i++) begin
      if (pg_kind[i] == KIND_FREE) begin
        if (got == 0) start = i;
        got++;
        if (got == want) break;
      end else begin
        got = 0;
      end
    end
    if (got != want) return ST_NO_RUN;
    for (int i = start; i < start + want; i++) begin
      pg_kind[i]  = (i == start) ? KIND_RUN : KIND_TAIL;
      pg_count[i] = want;
      stack_drop(i);
    end
    grant = start * PAGE_SZ;
    return ST_OK;
  endfunction

  function void release_at(int off);
    int page, c, cs, bpp, idx, n;
    bit was_full;
    page = off / PAGE_SZ;
    if (page >= managed) return;
    if (pg_kind[page] == KIND_SPLIT) begin
      c   = pg_class[page];
      cs  = MIN_BLK << c;
      bpp = PAGE_SZ / cs;
      idx = (off % PAGE_SZ) / cs;
      if (idx >= bpp) return;
      blk_next[page*BLK_MAX + idx] = pg_head[page];
      pg_head[page] = idx;
      was_full = (pg_count[page] == 0);
      pg_count[page]++;
      if (pg_count[page] >= bpp) begin
        pg_kind[page]  = KIND_FREE;
        pg_count[page] = 0;
        stack_add(page);
        class_drop(c, page);
      end else if (was_full) begin
        class_add(c, page);
      end
    end else if (pg_kind[page] == KIND_RUN) begin
      n = pg_count[page];
      for (int i = page; i < page + n && i < managed; i++) begin
        if (i != page && pg_kind[i] != KIND_TAIL) break;
        pg_kind[i]  = KIND_FREE;
        pg_count[i] = 0;
        stack_add(i);
      end
    end
  endfunction

  function grant_t apply_cmd(func_t f, int bytes, int off);
    grant_t r;
    int g;
    g = 0;
    r.status = ST_OK;
    case (f)
      FUNC_ALLOC: begin
        if (bytes <= PAGE_SZ/2) r.status = carve_block(bytes, g);
        else r.status = claim_run(bytes, g);
        if (r.status != ST_OK) g = 0;
      end
      FUNC_FREE:     release_at(off);
      FUNC_FREE_ALL: arena_reset();
      default: ;
    endcase
    r.grant = g[11:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  grant_t pending_grants[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;       // no idling on either side
  bit     hold_req = 1'b0;   // ask the receiver for one long hold-off
  int     n_cmds = 0, n_alloc_ok = 0, n_alloc_fail = 0, n_frees = 0, n_cfg = 0;
  int     live[$];           // offsets currently handed out

  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected beat grant=%0d status=%0d", $time,
                 m_axis_tdata[11:0], m_axis_tdata[13:12]);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tdata[11:0] !== want.grant) begin
          $display("%0t: grant_offset expected %0d actual %0d", $time,
                   want.grant, m_axis_tdata[11:0]);
          mismatches++;
        end
        if (m_axis_tdata[13:12] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, m_axis_tdata[13:12]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one beat and hold it until accepted; valid stays high afterwards.
  task automatic send_cmd(func_t f, int bytes, int off, bit typed,
                          logic [11:0] g, status_t st);
    grant_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'd0, off[11:0], bytes[12:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = apply_cmd(f, bytes[12:0], off[11:0]);
    if (typed) begin
      r.grant  = g;
      r.status = st;
    end
    pending_grants.insert(pending_grants.size(), r);
    n_cmds++;
    if (f == FUNC_ALLOC) begin
      if (r.status == ST_OK) begin
        n_alloc_ok++;
        live.insert(live.size(), int'(r.grant));
      end else begin
        n_alloc_fail++;
      end
    end
    if (f == FUNC_FREE) n_frees++;
    if (f == FUNC_FREE_ALL) live.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write pages_in_use once the block is idle; it re-initializes the arena.
  task automatic write_pages(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    managed = (v < 1) ? 1 : (v > PAGES) ? PAGES : v;
    arena_reset();
    live.delete();
    n_cfg++;
  endtask

  task automatic random_cmd();
    int r, idx, bytes, off;
    func_t f;
    r     = $urandom_range(0, 99);
    bytes = $urandom_range(0, 8191);
    off   = $urandom_range(0, 4095);
    if (r == 0) f = FUNC_FREE_ALL;
    else if (r == 1) f = FUNC_NONE;
    else if (r < 57) f = FUNC_ALLOC;
    else f = FUNC_FREE;
    if (f == FUNC_ALLOC) begin
      r = $urandom_range(0, 99);
      if (r < 75) bytes = $urandom_range(0, 128);
      else if (r < 95) bytes = $urandom_range(129, 1024);
      else if (r < 98) bytes = $urandom_range(1025, 4096);
    end else if (f == FUNC_FREE && live.size() != 0 && $urandom_range(0, 7) != 0) begin
      // mostly return something actually handed out
      idx = $urandom_range(0, live.size() - 1);
      off = live[idx];
      live.delete(idx);
    end
    send_cmd(f, bytes, off, 1'b0, 12'd0, ST_OK);
  endtask

  row_t steps[] = '{
    '{ROW_CMD, FUNC_ALLOC,    0,    0,    1, 12'd3840, ST_OK},        // zero bytes
    '{ROW_CMD, FUNC_ALLOC,    16,   0,    1, 12'd3856, ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    17,   0,    1, 12'd3584, ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    128,  0,    1, 12'd3328, ST_OK},        // largest class
    '{ROW_CMD, FUNC_ALLOC,    129,  0,    1, 12'd0,    ST_OK},        // one-page run
    '{ROW_CMD, FUNC_ALLOC,    4096, 0,    1, 12'd0,    ST_FEW_PAGES},
    '{ROW_CMD, FUNC_ALLOC,    8191, 0,    1, 12'd0,    ST_FEW_PAGES},
    '{ROW_CMD, FUNC_NONE,     8191, 4095, 1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_FREE,     0,    4095, 1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_FREE,     0,    3856, 1, 12'd0,    ST_OK},        // page back to stack
    '{ROW_CMD, FUNC_FREE,     0,    3840, 1, 12'd0,    ST_OK},        // page already free
    '{ROW_CMD, FUNC_FREE,     0,    0,    1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    3000, 0,    0, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_FREE,     0,    256,  1, 12'd0,    ST_OK},        // later page of run
    '{ROW_CMD, FUNC_ALLOC,    64,   0,    0, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_FREE_ALL, 0,    0,    1, 12'd0,    ST_OK},
    '{ROW_CFG, FUNC_NONE,     0,    0,    0, 12'd0,    ST_OK},        // saturates to 1
    '{ROW_CMD, FUNC_ALLOC,    129,  0,    1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    0,    0,    1, 12'd0,    ST_NO_PAGE},
    '{ROW_CFG, FUNC_NONE,     4,    0,    0, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    0,    0,    1, 12'd768,  ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    129,  0,    1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    129,  0,    1, 12'd256,  ST_OK},
    '{ROW_CMD, FUNC_FREE,     0,    0,    1, 12'd0,    ST_OK},
    '{ROW_CMD, FUNC_ALLOC,    300,  0,    1, 12'd0,    ST_NO_RUN},    // free pages split
    '{ROW_CFG, FUNC_NONE,     31,   0,    0, 12'd0,    ST_OK},        // saturates to 16
    '{ROW_CMD, FUNC_ALLOC,    4096, 0,    1, 12'd0,    ST_OK},        // whole arena
    '{ROW_CMD, FUNC_FREE,     0,    0,    1, 12'd0,    ST_OK}
  };

  initial begin
    int pg;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_NONE;
    managed       = PAGES;
    arena_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) write_pages(steps[i].bytes);
      else send_cmd(steps[i].func, steps[i].bytes, steps[i].offset, steps[i].typed,
                    steps[i].grant, steps[i].status);
    end

    // Random phases, each under its own page count
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       pg = PAGES;
        1:       pg = 1;
        2:       pg = $urandom_range(2, 8);
        3:       pg = $urandom_range(9, 15);
        4:       pg = $urandom_range(0, 31);
        default: pg = PAGES;
      endcase
      write_pages(pg);
      calm = (ph == PHASES - 1);
      if (ph == 0) hold_req = 1'b1;   // block fills up while the sender keeps offering
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 2 && n == PHASE_LEN / 2) drain();
        if (!calm && $urandom_range(0, 7) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        random_cmd();
      end
    end

    drain();
    $display("Covered %0d commands under %0d page-count writes: %0d grants, %0d refusals,",
             n_cmds, n_cfg, n_alloc_ok, n_alloc_fail);
    $display("%0d frees, with random stalls on both sides and one long receiver hold.",
             n_frees);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
